/* rtl/efab_pkg.sv */
// shared types and constants for the elementwise float alu with broadcast
package efab_pkg;

    localparam int VALUE_W = 32;
    localparam int LEN_W   = 11;
    localparam int IDX_W   = 10;
    localparam int POS_LIMIT = 1024;

    localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;

    typedef enum logic [2:0] {
        OP_ADD  = 3'd0,
        OP_SUB  = 3'd1,
        OP_MUL  = 3'd2,
        OP_DIV  = 3'd3,
        OP_RELU = 3'd4
    } t_arith_op;

    // configuration register indexes
    localparam logic CFG_ARITH_OP = 1'b0;
    localparam logic CFG_B_LENGTH = 1'b1;

    // transaction kinds
    localparam logic OPN_LOAD = 1'b0;
    localparam logic OPN_ELEM = 1'b1;

    typedef enum logic [1:0] {
        FOP_ADD = 2'd0,
        FOP_SUB = 2'd1,
        FOP_MUL = 2'd2,
        FOP_DIV = 2'd3
    } t_fpu_op;

    typedef struct packed {
        logic    start;
        t_fpu_op op;
    } t_fpu_req;

    typedef enum logic [3:0] {
        FS_IDLE,
        FS_PRE,
        FS_ALIGN,
        FS_ADD,
        FS_MUL,
        FS_MUL2,
        FS_DIVSET,
        FS_DIV,
        FS_NORM,
        FS_UNDER,
        FS_ROUND,
        FS_DONE
    } t_fpu_state;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_WAIT,
        ST_DONE
    } t_top_state;

endpackage

/* rtl/efab_fpu.sv */
// iterative binary32 add, subtract, multiply and divide unit
module efab_fpu (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  efab_pkg::t_fpu_req  i_req,
    input  logic [31:0]         i_a,
    input  logic [31:0]         i_b,
    output logic                o_done,
    output logic [31:0]         o_result
);

    efab_pkg::t_fpu_state r_state, n_state;
    efab_pkg::t_fpu_op    r_op, n_op;
    logic                 r_sa, n_sa, r_sb, n_sb, r_s, n_s;
    logic signed [11:0]   r_ea, n_ea, r_eb, n_eb, r_e, n_e;
    logic [26:0]          r_ma, n_ma, r_mb, n_mb;
    logic [27:0]          r_m, n_m;
    logic [25:0]          r_q, n_q;
    logic [24:0]          r_rem, n_rem;
    logic [47:0]          r_prod, n_prod;
    logic [4:0]           r_cnt, n_cnt;
    logic [31:0]          r_res, n_res;

    // operand decode
    logic [7:0]  ae, be;
    logic        anan, bnan, ainf, binf, azero, bzero, sbe, sx;
    logic        special;
    logic [31:0] spec_res;
    logic signed [11:0] ae_e, be_e;
    logic [26:0] am, bm;

    // rounding
    logic        inc;
    logic [24:0] rsum;
    logic [23:0] rmant;
    logic signed [11:0] ref_e;
    logic signed [11:0] diff;

    always_comb begin
        ae    = i_a[30:23];
        be    = i_b[30:23];
        anan  = (ae == 8'hFF) && (i_a[22:0] != 23'd0);
        bnan  = (be == 8'hFF) && (i_b[22:0] != 23'd0);
        ainf  = (ae == 8'hFF) && (i_a[22:0] == 23'd0);
        binf  = (be == 8'hFF) && (i_b[22:0] == 23'd0);
        azero = (i_a[30:0] == 31'd0);
        bzero = (i_b[30:0] == 31'd0);
        sbe   = i_b[31] ^ (i_req.op == efab_pkg::FOP_SUB);
        sx    = i_a[31] ^ i_b[31];
        ae_e  = (ae == 8'd0) ? 12'sd1 : $signed({4'd0, ae});
        be_e  = (be == 8'd0) ? 12'sd1 : $signed({4'd0, be});
        am    = {ae != 8'd0, i_a[22:0], 3'b000};
        bm    = {be != 8'd0, i_b[22:0], 3'b000};
        special  = 1'b1;
        spec_res = efab_pkg::CANON_NAN;
        unique case (i_req.op)
            efab_pkg::FOP_ADD, efab_pkg::FOP_SUB: begin
                if (anan || bnan)        spec_res = efab_pkg::CANON_NAN;
                else if (ainf && binf)   spec_res = (i_a[31] != sbe) ? efab_pkg::CANON_NAN : i_a;
                else if (ainf)           spec_res = i_a;
                else if (binf)           spec_res = {sbe, i_b[30:0]};
                else if (azero && bzero) spec_res = {i_a[31] & sbe, 31'd0};
                else if (bzero)          spec_res = i_a;
                else if (azero)          spec_res = {sbe, i_b[30:0]};
                else                     special  = 1'b0;
            end
            efab_pkg::FOP_MUL: begin
                if (anan || bnan)                          spec_res = efab_pkg::CANON_NAN;
                else if ((ainf && bzero) || (binf && azero)) spec_res = efab_pkg::CANON_NAN;
                else if (ainf || binf)                     spec_res = {sx, 8'hFF, 23'd0};
                else if (azero || bzero)                   spec_res = {sx, 31'd0};
                else                                       special  = 1'b0;
            end
            efab_pkg::FOP_DIV: begin
                if (anan || bnan)       spec_res = efab_pkg::CANON_NAN;
                else if (bzero)         spec_res = azero ? efab_pkg::CANON_NAN : {sx, 8'hFF, 23'd0};
                else if (ainf && binf)  spec_res = efab_pkg::CANON_NAN;
                else if (ainf)          spec_res = {sx, 8'hFF, 23'd0};
                else if (binf || azero) spec_res = {sx, 31'd0};
                else                    special  = 1'b0;
            end
            default: special = 1'b1;
        endcase
    end

    always_comb begin
        inc   = r_m[2] & (r_m[1] | r_m[0] | r_m[3]);
        rsum  = {1'b0, r_m[26:3]} + {24'd0, inc};
        if (rsum[24]) begin
            rmant = rsum[24:1];
            ref_e = r_e + 12'sd1;
        end else begin
            rmant = rsum[23:0];
            ref_e = r_e;
        end
        diff = r_ea - r_eb;
    end

    always_comb begin
        n_state = r_state;
        n_op = r_op;   n_sa = r_sa;   n_sb = r_sb;   n_s = r_s;
        n_ea = r_ea;   n_eb = r_eb;   n_e = r_e;
        n_ma = r_ma;   n_mb = r_mb;   n_m = r_m;
        n_q = r_q;     n_rem = r_rem; n_prod = r_prod;
        n_cnt = r_cnt; n_res = r_res;
        o_done = 1'b0;
        unique case (r_state)
            efab_pkg::FS_IDLE: begin
                if (i_req.start) begin
                    n_op = i_req.op;
                    if (special) begin
                        n_res   = spec_res;
                        n_state = efab_pkg::FS_DONE;
                    end else if (i_req.op == efab_pkg::FOP_ADD ||
                                 i_req.op == efab_pkg::FOP_SUB) begin
                        // larger exponent goes to the a side
                        if (ae_e < be_e) begin
                            n_sa = sbe;      n_ea = be_e; n_ma = bm;
                            n_sb = i_a[31];  n_eb = ae_e; n_mb = am;
                        end else begin
                            n_sa = i_a[31];  n_ea = ae_e; n_ma = am;
                            n_sb = sbe;      n_eb = be_e; n_mb = bm;
                        end
                        n_state = efab_pkg::FS_ALIGN;
                    end else begin
                        n_s  = sx;
                        n_ea = ae_e; n_ma = am;
                        n_eb = be_e; n_mb = bm;
                        n_state = efab_pkg::FS_PRE;
                    end
                end
            end
            efab_pkg::FS_PRE: begin
                // bring subnormal operands to a leading one
                if (!r_ma[26]) begin
                    n_ma = {r_ma[25:0], 1'b0};
                    n_ea = r_ea - 12'sd1;
                end else if (!r_mb[26]) begin
                    n_mb = {r_mb[25:0], 1'b0};
                    n_eb = r_eb - 12'sd1;
                end else if (r_op == efab_pkg::FOP_MUL) begin
                    n_state = efab_pkg::FS_MUL;
                end else begin
                    n_state = efab_pkg::FS_DIVSET;
                end
            end
            efab_pkg::FS_ALIGN: begin
                if (diff > 12'sd27) begin
                    n_mb = {26'd0, |r_mb};
                    n_eb = r_ea;
                end else if (diff != 12'sd0) begin
                    n_mb = {1'b0, r_mb[26:2], r_mb[1] | r_mb[0]};
                    n_eb = r_eb + 12'sd1;
                end else begin
                    n_state = efab_pkg::FS_ADD;
                end
            end
            efab_pkg::FS_ADD: begin
                n_e = r_ea;
                if (r_sa == r_sb) begin
                    n_m = {1'b0, r_ma} + {1'b0, r_mb};
                    n_s = r_sa;
                end else if (r_ma >= r_mb) begin
                    n_m = {1'b0, r_ma} - {1'b0, r_mb};
                    n_s = r_sa;
                end else begin
                    n_m = {1'b0, r_mb} - {1'b0, r_ma};
                    n_s = r_sb;
                end
                if (r_sa != r_sb && r_ma == r_mb) begin
                    n_res   = 32'd0;
                    n_state = efab_pkg::FS_DONE;
                end else begin
                    n_state = efab_pkg::FS_NORM;
                end
            end
            efab_pkg::FS_MUL: begin
                n_prod  = r_ma[26:3] * r_mb[26:3];
                n_state = efab_pkg::FS_MUL2;
            end
            efab_pkg::FS_MUL2: begin
                n_m = {1'b0, r_prod[47:22], |r_prod[21:0]};
                n_e = r_ea + r_eb - 12'sd126;
                n_state = efab_pkg::FS_NORM;
            end
            efab_pkg::FS_DIVSET: begin
                if (r_ma[26:3] < r_mb[26:3]) begin
                    n_rem = {r_ma[26:3], 1'b0};
                    n_e   = r_ea - r_eb + 12'sd126;
                end else begin
                    n_rem = {1'b0, r_ma[26:3]};
                    n_e   = r_ea - r_eb + 12'sd127;
                end
                n_cnt   = 5'd0;
                n_q     = 26'd0;
                n_state = efab_pkg::FS_DIV;
            end
            efab_pkg::FS_DIV: begin
                // one restoring quotient bit per cycle
                if (r_rem >= {1'b0, r_mb[26:3]}) begin
                    n_q   = {r_q[24:0], 1'b1};
                    n_rem = {r_rem[23:0] - r_mb[26:3], 1'b0};
                end else begin
                    n_q   = {r_q[24:0], 1'b0};
                    n_rem = {r_rem[23:0], 1'b0};
                end
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd25) begin
                    n_m     = {1'b0, n_q, r_rem >= {1'b0, r_mb[26:3]} ?
                               (r_rem != {1'b0, r_mb[26:3]}) : (r_rem != 25'd0)};
                    n_state = efab_pkg::FS_NORM;
                end
            end
            efab_pkg::FS_NORM: begin
                if (r_m[27]) begin
                    n_m = {1'b0, r_m[27:2], r_m[1] | r_m[0]};
                    n_e = r_e + 12'sd1;
                end else if (!r_m[26] && r_e > 12'sd1) begin
                    n_m = {r_m[26:0], 1'b0};
                    n_e = r_e - 12'sd1;
                end else begin
                    n_state = efab_pkg::FS_UNDER;
                end
            end
            efab_pkg::FS_UNDER: begin
                // denormalize toward the subnormal range
                if (r_e < 12'sd1) begin
                    n_m = {1'b0, r_m[27:2], r_m[1] | r_m[0]};
                    n_e = r_e + 12'sd1;
                end else begin
                    n_state = efab_pkg::FS_ROUND;
                end
            end
            efab_pkg::FS_ROUND: begin
                if (ref_e >= 12'sd255) begin
                    n_res = {r_s, 8'hFF, 23'd0};
                end else begin
                    n_res = {r_s, rmant[23] ? ref_e[7:0] : 8'd0, rmant[22:0]};
                end
                n_state = efab_pkg::FS_DONE;
            end
            efab_pkg::FS_DONE: begin
                o_done  = 1'b1;
                n_state = efab_pkg::FS_IDLE;
            end
            default: n_state = efab_pkg::FS_IDLE;
        endcase
    end

    assign o_result = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= efab_pkg::FS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op <= n_op;  r_sa <= n_sa;  r_sb <= n_sb;  r_s <= n_s;
        r_ea <= n_ea;  r_eb <= n_eb;  r_e <= n_e;
        r_ma <= n_ma;  r_mb <= n_mb;  r_m <= n_m;
        r_q <= n_q;    r_rem <= n_rem; r_prod <= n_prod;
        r_cnt <= n_cnt; r_res <= n_res;
    end

    ast_done_idle_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> r_state == efab_pkg::FS_IDLE)
        else $error("fpu did not return to idle after done");
    ast_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == efab_pkg::FS_DIV |-> r_cnt <= 5'd25)
        else $error("divide counter overran");
    ast_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == efab_pkg::FS_DIV |-> r_rem < {r_mb[26:3], 1'b0})
        else $error("divide remainder out of range");

endmodule

/* rtl/elementwise_float_alu_broadcast_core.sv */
// top level: b operand store, broadcast position and transaction sequencer
// a load completes on acceptance; relu and unused codes bypass the float unit; special float
//   operands go straight to done in the float unit; add/sub step through align and normalize,
//   multiply and divide through pre-normalize, normalize, denormalize (quotient: 1 bit/cycle)
// throughput: one transaction at a time, stall low only in idle; output stall holds it in done
// reset: synchronous active low; clears sequencer, position, out valid; arith_op to add, b_length to 1
module elementwise_float_alu_broadcast_core #(
    parameter int B_DEPTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_operation,
    input  logic [9:0]  i_b_index,
    input  logic [31:0] i_value,
    input  logic        i_first_of_pass,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_result,
    // configuration port
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [10:0] i_cfg_data
);

    // store address width and a compare width that covers index, length and depth
    localparam int AW  = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1;
    localparam int LW  = ((AW > 11) ? AW : 11) + 1;
    localparam int CAP = (B_DEPTH < efab_pkg::POS_LIMIT) ? B_DEPTH : efab_pkg::POS_LIMIT;

    efab_pkg::t_top_state r_state, n_state;

    logic [2:0]   r_arith_op;
    logic [10:0]  r_b_length;
    logic [AW-1:0] r_pos, n_pos;
    logic         r_out_valid, n_out_valid;
    logic [31:0]  r_out, n_out;
    logic [31:0]  r_a, r_res, n_res;
    logic [31:0]  r_rdata;
    logic [31:0]  r_bmem [B_DEPTH];

    logic         in_acc, load_acc, elem_acc, wr_ok;
    logic [10:0]  eff_len;
    logic [LW-1:0] idx_ext, pos_ext, len_ext, use_ext, nxt_ext;
    logic [AW-1:0] pos_use;

    efab_pkg::t_fpu_req fpu_req;
    logic         fpu_done;
    logic [31:0]  fpu_res;
    logic         a_nan, a_zero;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign load_acc = in_acc && (i_operation == efab_pkg::OPN_LOAD);
    assign elem_acc = in_acc && (i_operation == efab_pkg::OPN_ELEM);

    // effective broadcast length: zero acts as one, large values saturate
    always_comb begin
        if (r_b_length == 11'd0)
            eff_len = 11'd1;
        else if (r_b_length > 11'(CAP))
            eff_len = 11'(CAP);
        else
            eff_len = r_b_length;
    end

    always_comb begin
        idx_ext = LW'(i_b_index);
        wr_ok   = idx_ext < LW'(B_DEPTH);
        pos_ext = LW'(r_pos);
        len_ext = LW'(eff_len);
        if (i_first_of_pass || pos_ext >= len_ext)
            use_ext = '0;
        else
            use_ext = pos_ext;
        pos_use = use_ext[AW-1:0];
        nxt_ext = use_ext + LW'(1);
        n_pos   = r_pos;
        if (elem_acc)
            n_pos = (nxt_ext >= len_ext) ? '0 : nxt_ext[AW-1:0];
    end

    // b store, write on load and registered read on an element
    always_ff @(posedge i_clk) begin
        if (load_acc && wr_ok)
            r_bmem[idx_ext[AW-1:0]] <= i_value;
        if (elem_acc)
            r_rdata <= r_bmem[pos_use];
    end

    efab_fpu u_fpu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (fpu_req),
        .i_a      (r_a),
        .i_b      (r_rdata),
        .o_done   (fpu_done),
        .o_result (fpu_res)
    );

    assign a_nan  = (r_a[30:23] == 8'hFF) && (r_a[22:0] != 23'd0);
    assign a_zero = (r_a[30:0] == 31'd0);

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        fpu_req.start = 1'b0;
        fpu_req.op    = efab_pkg::FOP_ADD;
        unique case (r_state)
            efab_pkg::ST_IDLE: begin
                if (elem_acc)
                    n_state = efab_pkg::ST_EXEC;
            end
            efab_pkg::ST_EXEC: begin
                n_state = efab_pkg::ST_WAIT;
                unique case (r_arith_op)
                    efab_pkg::OP_ADD:  fpu_req = '{start: 1'b1, op: efab_pkg::FOP_ADD};
                    efab_pkg::OP_SUB:  fpu_req = '{start: 1'b1, op: efab_pkg::FOP_SUB};
                    efab_pkg::OP_MUL:  fpu_req = '{start: 1'b1, op: efab_pkg::FOP_MUL};
                    efab_pkg::OP_DIV:  fpu_req = '{start: 1'b1, op: efab_pkg::FOP_DIV};
                    efab_pkg::OP_RELU: begin
                        // negative non-nan nonzero goes to +0, all else passes
                        n_res   = (r_a[31] && !a_nan && !a_zero) ? 32'd0 : r_a;
                        n_state = efab_pkg::ST_DONE;
                    end
                    default: begin
                        n_res   = 32'd0;
                        n_state = efab_pkg::ST_DONE;
                    end
                endcase
            end
            efab_pkg::ST_WAIT: begin
                if (fpu_done) begin
                    n_res   = fpu_res;
                    n_state = efab_pkg::ST_DONE;
                end
            end
            efab_pkg::ST_DONE: begin
                // hand off once the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = efab_pkg::ST_IDLE;
                end
            end
            default: n_state = efab_pkg::ST_IDLE;
        endcase
    end

    assign o_in_stall  = (r_state != efab_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= efab_pkg::ST_IDLE;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
            r_arith_op  <= efab_pkg::OP_ADD;
            r_b_length  <= 11'd1;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    efab_pkg::CFG_ARITH_OP: r_arith_op <= i_cfg_data[2:0];
                    efab_pkg::CFG_B_LENGTH: r_b_length <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        r_out <= n_out;
        if (elem_acc)
            r_a <= i_value;
    end

    ast_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fpu_done |-> r_state == efab_pkg::ST_WAIT)
        else $error("float unit finished outside the wait state");
    ast_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == efab_pkg::ST_EXEC |-> LW'(r_pos) < LW'(eff_len))
        else $error("broadcast position beyond effective length");
    ast_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == efab_pkg::ST_DONE)
        else $error("result presented without a finished transaction");

endmodule

/* dv/tb_elementwise_float_alu_broadcast_core.sv */
// testbench for the elementwise float alu with broadcast b operand
module tb_elementwise_float_alu_broadcast_core;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic        i_operation;
    logic [9:0]  i_b_index;
    logic [31:0] i_value;
    logic        i_first_of_pass;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [31:0] o_result;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [10:0] i_cfg_data;

    elementwise_float_alu_broadcast_core #(.B_DEPTH(1024)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_operation(i_operation), .i_b_index(i_b_index),
        .i_value(i_value), .i_first_of_pass(i_first_of_pass),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_result(o_result),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    // shadow copy of the block state
    logic [31:0] shadow_b_store [0:1023];
    bit          shadow_b_written [0:1023];
    int unsigned shadow_pos;
    logic [2:0]  shadow_op;
    logic [10:0] shadow_len;

    logic [31:0] pending_results[$];
    int          mismatch_count;
    int          result_count;
    int          elem_count;
    int          load_count;
    int          stall_left;

    // special operand bit patterns
    localparam int N_SPECIAL = 12;
    logic [31:0] special_vals [0:N_SPECIAL-1] = '{
        32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
        32'h7FC0_0000, 32'hFF81_2345, 32'h0000_0001, 32'h807F_FFFF,
        32'h7F7F_FFFF, 32'h0080_0000, 32'h3F80_0000, 32'hBF80_0000
    };

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #(8 * 2000000);
        $display("Verification failed");
        $finish;
    end

    // widen binary32 bits to binary64 bits, exactly
    function automatic logic [63:0] sgl_to_dbl(logic [31:0] f);
        logic [7:0]  e;
        logic [22:0] m;
        int          de;
        e = f[30:23];
        m = f[22:0];
        if (e == 8'hFF)
            return {f[31], 11'h7FF, m, 29'd0};
        if (e == 8'd0) begin
            if (m == 23'd0)
                return {f[31], 63'd0};
            // subnormal: normalize the fraction
            de = -126;
            while (m[22] == 1'b0) begin
                m = m << 1;
                de = de - 1;
            end
            m = m << 1;
            de = de - 1;
            return {f[31], 11'(de + 1023), m, 29'd0};
        end
        return {f[31], 11'(int'(e) - 127 + 1023), m, 29'd0};
    endfunction

    // narrow binary64 bits to binary32, round to nearest even, nan made canonical
    function automatic logic [31:0] dbl_to_sgl(logic [63:0] d);
        logic        s;
        logic [10:0] de;
        logic [63:0] sig;
        logic [63:0] kept;
        logic [63:0] rem;
        logic [63:0] half;
        int          e;
        int          sh;
        int          fe;
        s = d[63];
        de = d[62:52];
        if (de == 11'h7FF)
            return (d[51:0] != 0) ? efab_pkg::CANON_NAN : {s, 31'h7F80_0000};
        if (de == 11'd0)
            return {s, 31'd0};
        e = int'(de) - 1023;
        sig = {11'd0, 1'b1, d[51:0]};
        sh = 29;
        if (e < -126)
            sh = 29 + (-126 - e);
        if (sh > 60)
            sh = 60;
        kept = sig >> sh;
        rem = sig & ((64'd1 << sh) - 1);
        half = 64'd1 << (sh - 1);
        if (rem > half || (rem == half && kept[0]))
            kept = kept + 1;
        if (e < -126)
            return {s, kept[30:0]};
        fe = e + 127;
        if (kept[24]) begin
            kept = kept >> 1;
            fe = fe + 1;
        end
        if (fe >= 255)
            return {s, 31'h7F80_0000};
        return {s, 8'(fe), kept[22:0]};
    endfunction

    function automatic bit is_nan32(logic [31:0] x);
        return x[30:23] == 8'hFF && x[22:0] != 23'd0;
    endfunction

    // expected result of one a element against one b word
    function automatic logic [31:0] alu_result(logic [2:0] op, logic [31:0] a,
                                               logic [31:0] b);
        real ra;
        real rb;
        ra = $bitstoreal(sgl_to_dbl(a));
        rb = $bitstoreal(sgl_to_dbl(b));
        case (op)
            efab_pkg::OP_ADD: return dbl_to_sgl($realtobits(ra + rb));
            efab_pkg::OP_SUB: return dbl_to_sgl($realtobits(ra - rb));
            efab_pkg::OP_MUL: return dbl_to_sgl($realtobits(ra * rb));
            efab_pkg::OP_DIV: begin
                if (b[30:0] == 31'd0) begin
                    if (a[30:0] == 31'd0 || is_nan32(a))
                        return efab_pkg::CANON_NAN;
                    return {a[31] ^ b[31], 31'h7F80_0000};
                end
                return dbl_to_sgl($realtobits(ra / rb));
            end
            efab_pkg::OP_RELU:
                return (a[31] && a[30:0] != 31'd0 && !is_nan32(a)) ? 32'd0 : a;
            default: return 32'd0;
        endcase
    endfunction

    function automatic int unsigned eff_length();
        if (shadow_len == 11'd0)
            return 1;
        if (shadow_len > 11'd1024)
            return 1024;
        return shadow_len;
    endfunction

    // position the next a element will read
    function automatic int unsigned read_position(bit first);
        int unsigned p;
        p = first ? 0 : shadow_pos;
        if (p >= eff_length())
            p = 0;
        return p;
    endfunction

    function automatic logic [31:0] rand_float();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2)
            return special_vals[$urandom_range(0, N_SPECIAL - 1)];
        if (r < 5)
            return $urandom;
        if (r < 6)
            return {1'($urandom), 8'd0, 23'($urandom)};
        return {1'($urandom), 8'($urandom_range(110, 145)), 23'($urandom)};
    endfunction

    task automatic idle_gap();
        int r;
        r = $urandom_range(0, 19);
        if (r < 13)
            return;
        i_in_valid <= 1'b0;
        if (r < 18)
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        else
            repeat ($urandom_range(10, 40)) @(posedge i_clk);
    endtask

    // drive one transaction, wait for acceptance, update the shadow state
    task automatic send_txn(logic op, logic [9:0] idx, logic [31:0] val, logic first);
        int unsigned p;
        i_in_valid      <= 1'b1;
        i_operation     <= op;
        i_b_index       <= idx;
        i_value         <= val;
        i_first_of_pass <= first;
        do @(posedge i_clk); while (o_in_stall);
        if (op == efab_pkg::OPN_LOAD) begin
            shadow_b_store[idx] = val;
            shadow_b_written[idx] = 1'b1;
            load_count++;
        end else begin
            p = read_position(first);
            pending_results.push_back(alu_result(shadow_op, val, shadow_b_store[p]));
            p = p + 1;
            if (p >= eff_length())
                p = 0;
            shadow_pos = p;
            elem_count++;
        end
        idle_gap();
    endtask

    // a element; the b entry it reads gets loaded first if it never was
    task automatic send_elem(logic [31:0] val, logic first);
        int unsigned p;
        p = read_position(first);
        if (!shadow_b_written[p])
            send_txn(efab_pkg::OPN_LOAD, 10'(p), rand_float(), 1'($urandom));
        send_txn(efab_pkg::OPN_ELEM, 10'($urandom), val, first);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        // no transaction left in flight after the last result
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic idx, logic [10:0] data);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == efab_pkg::CFG_ARITH_OP)
            shadow_op = data[2:0];
        else
            shadow_len = data;
        @(posedge i_clk);
    endtask

    // every op code on the special operands, divide by zero included
    task automatic test_directed_ops();
        write_cfg(efab_pkg::CFG_B_LENGTH, 11'd2);
        send_txn(efab_pkg::OPN_LOAD, 10'd0, 32'h4000_0000, 1'b0);
        send_txn(efab_pkg::OPN_LOAD, 10'd1, 32'h8000_0000, 1'b0);
        for (int op = 0; op < 8; op++) begin
            write_cfg(efab_pkg::CFG_ARITH_OP, 11'(op));
            send_elem(special_vals[op % N_SPECIAL], 1'b1);
            send_elem(special_vals[(op + 3) % N_SPECIAL], 1'b0);
            send_elem(special_vals[(op + 7) % N_SPECIAL], 1'b0);
        end
    endtask

    // length extremes: zero, scalar, full store and above
    task automatic test_length_extremes();
        logic [10:0] lens [0:3] = '{11'd0, 11'd1, 11'd1024, 11'd2047};
        write_cfg(efab_pkg::CFG_ARITH_OP, 11'(efab_pkg::OP_MUL));
        foreach (lens[i]) begin
            write_cfg(efab_pkg::CFG_B_LENGTH, lens[i]);
            for (int k = 0; k < 6; k++)
                send_elem(rand_float(), 1'(k == 0));
        end
    endtask

    // sender waits for every outstanding result mid stream
    task automatic test_pause_for_results();
        write_cfg(efab_pkg::CFG_ARITH_OP, 11'(efab_pkg::OP_ADD));
        write_cfg(efab_pkg::CFG_B_LENGTH, 11'd3);
        for (int k = 0; k < 10; k++)
            send_elem(rand_float(), 1'(k == 0));
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        for (int k = 0; k < 10; k++)
            send_elem(rand_float(), 1'b0);
    endtask

    // random phases: op, length and stream content all random
    task automatic test_random_phases();
        int r;
        for (int ph = 0; ph < 16; ph++) begin
            r = $urandom_range(0, 9);
            write_cfg(efab_pkg::CFG_ARITH_OP, (r < 8) ? 11'($urandom_range(0, 4))
                                                      : 11'($urandom_range(5, 7)));
            r = $urandom_range(0, 9);
            if (r < 6)
                write_cfg(efab_pkg::CFG_B_LENGTH, 11'($urandom_range(1, 16)));
            else if (r < 8)
                write_cfg(efab_pkg::CFG_B_LENGTH, 11'($urandom_range(0, 2047)));
            else
                write_cfg(efab_pkg::CFG_B_LENGTH, (r == 8) ? 11'd1024 : 11'd1);
            repeat (50) begin
                if ($urandom_range(0, 5) == 0)
                    send_txn(efab_pkg::OPN_LOAD, 10'($urandom), rand_float(),
                             1'($urandom));
                else
                    send_elem(rand_float(), 1'($urandom_range(0, 7) == 0));
            end
        end
    endtask

    // result checker and random output stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left  <= 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                result_count++;
                if (pending_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result %h", o_result);
                end else if (pending_results[0] !== o_result) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("result mismatch: expected %h actual %h",
                                 pending_results[0], o_result);
                    void'(pending_results.pop_front());
                end else begin
                    void'(pending_results.pop_front());
                end
            end
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
            end else begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: begin
                        i_out_stall <= 1'b0;
                        stall_left  <= $urandom_range(1, 20);
                    end
                    6, 7, 8: begin
                        i_out_stall <= 1'b1;
                        stall_left  <= $urandom_range(0, 2);
                    end
                    default: begin
                        i_out_stall <= 1'b1;
                        stall_left  <= $urandom_range(20, 60);
                    end
                endcase
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_operation = efab_pkg::OPN_LOAD;
        i_b_index = '0;
        i_value = '0;
        i_first_of_pass = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = efab_pkg::CFG_ARITH_OP;
        i_cfg_data = '0;
        mismatch_count = 0;
        result_count = 0;
        elem_count = 0;
        load_count = 0;
        shadow_pos = 0;
        shadow_op = efab_pkg::OP_ADD;
        shadow_len = 11'd1;
        foreach (shadow_b_written[i])
            shadow_b_written[i] = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_ops();
        test_length_extremes();
        test_pause_for_results();
        test_random_phases();
        drain();

        $display("covered %0d a elements and %0d b loads, %0d results checked",
                 elem_count, load_count, result_count);
        $display("all op codes, lengths 0 to 2047, special float operands, random stalls");
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("mismatches %0d, results left %0d", mismatch_count,
                     pending_results.size());
            $display("Verification failed");
        end
        $finish;
    end

endmodule
